>>> src/terminal_key_decoder_unit_defines.svh
// Assertion macros used by the checker module.
`ifndef TERMINAL_KEY_DECODER_UNIT_DEFINES_SVH
`define TERMINAL_KEY_DECODER_UNIT_DEFINES_SVH

// Check that is switched off while reset is high.
`define TKD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that also holds across reset.
`define TKD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/tkd_pkg.sv
package tkd_pkg;

   // Escape sequence tracker phases
   typedef enum logic [2:0] {
      PH_OUT     = 3'd0,
      PH_START   = 3'd1,
      PH_BAD     = 3'd2,
      PH_BRACKET = 3'd3,
      PH_BR1     = 3'd4,
      PH_BR3     = 3'd5,
      PH_BR4     = 3'd6,
      PH_O       = 3'd7
   } phase_type;

   // Byte values
   localparam logic [7:0] BYTE_LF    = 8'h0A;
   localparam logic [7:0] BYTE_CR    = 8'h0D;
   localparam logic [7:0] BYTE_ESC   = 8'h1B;
   localparam logic [7:0] BYTE_LBRK  = 8'h5B; // '['
   localparam logic [7:0] BYTE_O     = 8'h4F; // 'O'
   localparam logic [7:0] BYTE_TILDE = 8'h7E; // '~'
   localparam logic [7:0] BYTE_ONE   = 8'h31;
   localparam logic [7:0] BYTE_THREE = 8'h33;
   localparam logic [7:0] BYTE_FOUR  = 8'h34;
   localparam logic [7:0] BYTE_UA    = 8'h41; // 'A'
   localparam logic [7:0] BYTE_UB    = 8'h42;
   localparam logic [7:0] BYTE_UC    = 8'h43;
   localparam logic [7:0] BYTE_UD    = 8'h44;
   localparam logic [7:0] BYTE_UF    = 8'h46;
   localparam logic [7:0] BYTE_UZ    = 8'h5A;
   localparam logic [7:0] BYTE_LA    = 8'h61; // 'a'
   localparam logic [7:0] BYTE_LZ    = 8'h7A;

   // Extended key codes
   localparam logic [8:0] KEY_UP         = 9'd256;
   localparam logic [8:0] KEY_DOWN       = 9'd257;
   localparam logic [8:0] KEY_RIGHT      = 9'd258;
   localparam logic [8:0] KEY_LEFT       = 9'd259;
   localparam logic [8:0] KEY_END        = 9'd260;
   localparam logic [8:0] KEY_LINE_BEGIN = 9'd261;
   localparam logic [8:0] KEY_DELETE     = 9'd262;

   // Widths of the stream payloads
   localparam int RX_W   = 8;
   localparam int KEY_W  = 9;
   localparam int REQ_DW = 8;
   localparam int RSP_DW = 16;

endpackage

>>> src/terminal_key_decoder_unit.sv
// Terminal key decoder: console bytes in, key codes out.
// An accepted byte that gives a key code shows it on rsp_ in the next cycle.
// Throughput: one byte per cycle; the single result register is refilled
// in the cycle it is taken, so req_tready only drops while a key code waits.
// Reset (synchronous, active high) clears the line-ending flag, returns the
// escape tracker to outside any sequence and empties the result register.
module terminal_key_decoder_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [tkd_pkg::REQ_DW-1:0] req_tdata,  // [7:0] rx_byte
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [tkd_pkg::RSP_DW-1:0] rsp_tdata   // [8:0] key_code, [15:9] zero
);
   import tkd_pkg::*;

   phase_type              phase_ff, phase_in;
   logic                   prev_cr_ff, prev_cr_in;
   logic                   valid_ff, valid_in;
   logic [KEY_W-1:0]       key_ff, key_in;
   logic [RX_W-1:0]        rx_byte;
   logic [RX_W-1:0]        fold_byte;
   logic                   accept;
   logic                   swallow_lf;
   logic                   ends_seq;
   logic                   emit;
   logic [KEY_W-1:0]       key_code;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !valid_ff || rsp_tready;
   assign rx_byte    = req_tdata[RX_W-1:0];

   // CR folds to LF; an LF right after a CR is dropped
   assign fold_byte  = (rx_byte == BYTE_CR) ? BYTE_LF : rx_byte;
   assign swallow_lf = (rx_byte == BYTE_LF) && prev_cr_ff;
   assign prev_cr_in = accept ? (rx_byte == BYTE_CR) : prev_cr_ff;

   // Letters and tilde close a sequence
   assign ends_seq = ((fold_byte >= BYTE_UA) && (fold_byte <= BYTE_UZ)) ||
                     ((fold_byte >= BYTE_LA) && (fold_byte <= BYTE_LZ)) ||
                     (fold_byte == BYTE_TILDE);

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept && !swallow_lf) begin
         if (fold_byte == BYTE_ESC) begin
            phase_in = PH_START;
         end else begin
            unique case (phase_ff)
               PH_OUT: phase_in = PH_OUT;
               PH_START: begin
                  if (fold_byte == BYTE_LBRK)   phase_in = PH_BRACKET;
                  else if (fold_byte == BYTE_O) phase_in = PH_O;
                  else                          phase_in = ends_seq ? PH_OUT : PH_BAD;
               end
               PH_BRACKET: begin
                  if (fold_byte == BYTE_ONE)        phase_in = PH_BR1;
                  else if (fold_byte == BYTE_THREE) phase_in = PH_BR3;
                  else if (fold_byte == BYTE_FOUR)  phase_in = PH_BR4;
                  else                              phase_in = ends_seq ? PH_OUT : PH_BAD;
               end
               default: phase_in = ends_seq ? PH_OUT : PH_BAD;
            endcase
         end
      end
   end

   // Key code and whether this byte gives one
   always_comb begin
      emit     = 1'b0;
      key_code = {1'b0, fold_byte};
      if (!swallow_lf && (fold_byte != BYTE_ESC)) begin
         unique case (phase_ff)
            PH_OUT: emit = 1'b1;
            PH_BRACKET: begin
               emit = 1'b1;
               if (fold_byte == BYTE_UA)      key_code = KEY_UP;
               else if (fold_byte == BYTE_UB) key_code = KEY_DOWN;
               else if (fold_byte == BYTE_UC) key_code = KEY_RIGHT;
               else if (fold_byte == BYTE_UD) key_code = KEY_LEFT;
               else                           emit = 1'b0;
            end
            PH_O: begin
               emit     = (fold_byte == BYTE_UF);
               key_code = KEY_END;
            end
            PH_BR1: begin
               emit     = (fold_byte == BYTE_TILDE);
               key_code = KEY_LINE_BEGIN;
            end
            PH_BR3: begin
               emit     = (fold_byte == BYTE_TILDE);
               key_code = KEY_DELETE;
            end
            PH_BR4: begin
               emit     = (fold_byte == BYTE_TILDE);
               key_code = KEY_END;
            end
            default: emit = 1'b0;
         endcase
      end
   end

   // Result register
   always_comb begin
      valid_in = valid_ff && !rsp_tready;
      key_in   = key_ff;
      if (accept) begin
         valid_in = emit;
         key_in   = key_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_OUT;
         prev_cr_ff <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         prev_cr_ff <= prev_cr_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{(RSP_DW-KEY_W){1'b0}}, key_ff};

endmodule

>>> src/tkd_checker.sv
`include "terminal_key_decoder_unit_defines.svh"

module tkd_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic [tkd_pkg::REQ_DW-1:0] req_tdata,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [tkd_pkg::RSP_DW-1:0] rsp_tdata
);
   import tkd_pkg::*;

   // A waiting key code is not withdrawn
   `TKD_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "rsp item dropped while stalled")

   // CR is always folded and ESC never passes through
   `TKD_ASSERT(a_no_cr_esc, clock, reset, rsp_tvalid |-> (rsp_tdata != {8'h00, BYTE_CR}) && (rsp_tdata != {8'h00, BYTE_ESC}), "CR or ESC reached the output")

   // Extended codes stay in range, padding is zero
   `TKD_ASSERT(a_key_range, clock, reset, rsp_tvalid |-> (rsp_tdata[15:9] == 7'd0) && (!rsp_tdata[8] || (rsp_tdata[7:0] <= 8'd6)), "key code out of range")

   // An accepted ESC never gives a key code
   `TKD_ASSERT(a_esc_silent, clock, reset, req_tvalid && req_tready && (req_tdata[7:0] == BYTE_ESC) |=> !rsp_tvalid, "key code after ESC")

   // Reset empties the result register
   `TKD_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid, "rsp valid after reset")

endmodule

bind terminal_key_decoder_unit tkd_checker u_tkd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
